/* sv/assert_macros.svh */
// Assertion macros used by the tkst_checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition that holds at every edge out of reset.
`define ASSERT_ALWAYS(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// Antecedent at one edge implies the consequent at the next edge.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* sv/tkst_pkg.sv */
// ----------------------------------------------------------------------------
// tkst_pkg
// Types and constants shared by the top-k score table.
// ----------------------------------------------------------------------------
package tkst_pkg;

	localparam int unsigned DEF_TABLE_DEPTH  = 10;
	localparam int unsigned DEF_POINT_BITS   = 16;
	localparam int unsigned DEF_PAYLOAD_BITS = 32;

	localparam int unsigned READ_IDX_BITS = 4;
	localparam int unsigned COUNT_BITS    = 5;

	typedef enum logic {
		ACT_INSERT = 1'b0,
		ACT_READ   = 1'b1
	} action_t;

	// link between neighbouring cells
	typedef struct packed {
		logic valid;   // cell holds an entry
		logic after;   // newcomer ranks after this cell
	} link_t;

endpackage

/* sv/tkst_if.sv */
// ----------------------------------------------------------------------------
// tkst_in_if / tkst_out_if
// Valid/ready channels carrying command and result words.
// ----------------------------------------------------------------------------
interface tkst_in_if import tkst_pkg::*; #(
	parameter int unsigned POINT_BITS   = DEF_POINT_BITS,
	parameter int unsigned PAYLOAD_BITS = DEF_PAYLOAD_BITS
);
	logic                     valid;
	logic                     ready;
	logic                     action;
	logic [POINT_BITS-1:0]    new_points;
	logic [PAYLOAD_BITS-1:0]  new_payload;
	logic [READ_IDX_BITS-1:0] read_index;

	modport source (output valid, action, new_points, new_payload, read_index,
		input ready);
	modport sink (input valid, action, new_points, new_payload, read_index,
		output ready);
endinterface

interface tkst_out_if import tkst_pkg::*; #(
	parameter int unsigned POINT_BITS   = DEF_POINT_BITS,
	parameter int unsigned PAYLOAD_BITS = DEF_PAYLOAD_BITS
);
	logic                    valid;
	logic                    ready;
	logic                    accepted;
	logic [COUNT_BITS-1:0]   entry_count;
	logic [POINT_BITS-1:0]   top_points;
	logic                    read_valid;
	logic [POINT_BITS-1:0]   read_points;
	logic [PAYLOAD_BITS-1:0] read_payload;

	modport source (output valid, accepted, entry_count, top_points, read_valid,
		read_points, read_payload, input ready);
	modport sink (input valid, accepted, entry_count, top_points, read_valid,
		read_points, read_payload, output ready);
endinterface

/* sv/tkst_cell.sv */
// ----------------------------------------------------------------------------
// tkst_cell
// One rank of the table: keeps, takes the newcomer, or takes its upper
// neighbour's entry.
// ----------------------------------------------------------------------------
module tkst_cell import tkst_pkg::*; #(
	parameter int unsigned POINT_BITS   = DEF_POINT_BITS,
	parameter int unsigned PAYLOAD_BITS = DEF_PAYLOAD_BITS
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    wr_en,
	input  logic [POINT_BITS-1:0]   new_points,
	input  logic [PAYLOAD_BITS-1:0] new_payload,
	input  link_t                   prev_link,
	input  logic [POINT_BITS-1:0]   prev_points,
	input  logic [PAYLOAD_BITS-1:0] prev_payload,
	output link_t                   link,
	output logic [POINT_BITS-1:0]   points,
	output logic [PAYLOAD_BITS-1:0] payload
);

	logic                    valid_q;
	logic [POINT_BITS-1:0]   points_q;
	logic [PAYLOAD_BITS-1:0] payload_q;
	logic                    after;

	assign after = valid_q && (points_q >= new_points);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (wr_en) begin
			valid_q <= valid_q | prev_link.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en && !after) begin
			if (prev_link.after) begin
				points_q  <= new_points;
				payload_q <= new_payload;
			end else begin
				points_q  <= prev_points;
				payload_q <= prev_payload;
			end
		end
	end

	assign link    = '{valid: valid_q, after: after};
	assign points  = points_q;
	assign payload = payload_q;

endmodule

/* sv/top_k_score_table.sv */
// ----------------------------------------------------------------------------
// top_k_score_table
// Keeps the best TABLE_DEPTH (points, payload) entries in descending order.
// ----------------------------------------------------------------------------
// Takes one word per cycle unless stalled, and returns one result word in the
// cycle after it is taken, from an output register; a new word is taken while
// the previous result is being handed over. An insert is placed by a row of
// cells that each compare their entry with the broadcast newcomer and keep,
// take it, or shift down from the cell above. Ties go after existing entries;
// zero points, or a full table whose last entry is not beaten, is rejected.
// A read returns the entry at read_index, zeros beyond the count.
module top_k_score_table import tkst_pkg::*; #(
	parameter int unsigned TABLE_DEPTH  = DEF_TABLE_DEPTH,
	parameter int unsigned POINT_BITS   = DEF_POINT_BITS,
	parameter int unsigned PAYLOAD_BITS = DEF_PAYLOAD_BITS
) (
	input  logic      clk,
	input  logic      arst_n,
	tkst_in_if.sink   item,
	tkst_out_if.source res
);

	localparam int unsigned CNT_W = $clog2(TABLE_DEPTH + 1);

	link_t                   lnk      [TABLE_DEPTH+1];
	logic [POINT_BITS-1:0]   cell_pts [TABLE_DEPTH];
	logic [PAYLOAD_BITS-1:0] cell_pay [TABLE_DEPTH];

	logic [CNT_W-1:0]        count_q;
	logic                    fire;
	logic                    is_insert;
	logic                    accept;
	logic                    full;
	logic [CNT_W-1:0]        count_nxt;
	logic [POINT_BITS-1:0]   top_nxt;
	logic                    rd_valid;
	logic [POINT_BITS-1:0]   rd_pts;
	logic [PAYLOAD_BITS-1:0] rd_pay;

	logic                    res_valid_q;
	logic                    accepted_q;
	logic [CNT_W-1:0]        count_out_q;
	logic [POINT_BITS-1:0]   top_q;
	logic                    rd_valid_q;
	logic [POINT_BITS-1:0]   rd_pts_q;
	logic [PAYLOAD_BITS-1:0] rd_pay_q;

	assign item.ready = !res_valid_q || res.ready;
	assign fire       = item.valid && item.ready;
	assign is_insert  = (action_t'(item.action) == ACT_INSERT);
	assign full       = (count_q == CNT_W'(TABLE_DEPTH));

	// last cell still ranks ahead of the newcomer: nothing would move
	assign accept = is_insert && (item.new_points != '0) && !lnk[TABLE_DEPTH].after;

	assign lnk[0] = '{valid: 1'b1, after: 1'b1};

	for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
		logic [POINT_BITS-1:0]   up_pts;
		logic [PAYLOAD_BITS-1:0] up_pay;

		if (i == 0) begin : g_head
			assign up_pts = item.new_points;
			assign up_pay = item.new_payload;
		end else begin : g_body
			assign up_pts = cell_pts[i-1];
			assign up_pay = cell_pay[i-1];
		end

		tkst_cell #(
			.POINT_BITS   (POINT_BITS),
			.PAYLOAD_BITS (PAYLOAD_BITS)
		) u_cell (
			.clk          (clk),
			.arst_n       (arst_n),
			.wr_en        (fire && accept),
			.new_points   (item.new_points),
			.new_payload  (item.new_payload),
			.prev_link    (lnk[i]),
			.prev_points  (up_pts),
			.prev_payload (up_pay),
			.link         (lnk[i+1]),
			.points       (cell_pts[i]),
			.payload      (cell_pay[i])
		);
	end

	always_comb begin
		count_nxt = count_q;
		if (accept && !full) begin
			count_nxt = count_q + CNT_W'(1);
		end
		if (accept && !lnk[1].after) begin
			top_nxt = item.new_points;
		end else if (count_q != '0) begin
			top_nxt = cell_pts[0];
		end else begin
			top_nxt = '0;
		end
	end

	always_comb begin
		rd_valid = !is_insert &&
			(COUNT_BITS'(item.read_index) < COUNT_BITS'(count_q));
		rd_pts   = '0;
		rd_pay   = '0;
		for (int i = 0; i < TABLE_DEPTH; i++) begin
			if (rd_valid && (item.read_index == READ_IDX_BITS'(i))) begin
				rd_pts = cell_pts[i];
				rd_pay = cell_pay[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (fire) begin
				count_q     <= count_nxt;
				res_valid_q <= 1'b1;
			end else if (res.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			accepted_q  <= accept;
			count_out_q <= count_nxt;
			top_q       <= top_nxt;
			rd_valid_q  <= rd_valid;
			rd_pts_q    <= rd_pts;
			rd_pay_q    <= rd_pay;
		end
	end

	assign res.valid        = res_valid_q;
	assign res.accepted     = accepted_q;
	assign res.entry_count  = COUNT_BITS'(count_out_q);
	assign res.top_points   = top_q;
	assign res.read_valid   = rd_valid_q;
	assign res.read_points  = rd_pts_q;
	assign res.read_payload = rd_pay_q;

endmodule

/* sv/tkst_checker.sv */
// ----------------------------------------------------------------------------
// tkst_checker
// Port-level checks on the result channel of the top-k score table.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tkst_checker import tkst_pkg::*; #(
	parameter int unsigned TABLE_DEPTH  = DEF_TABLE_DEPTH,
	parameter int unsigned POINT_BITS   = DEF_POINT_BITS,
	parameter int unsigned PAYLOAD_BITS = DEF_PAYLOAD_BITS
) (
	input logic                    clk,
	input logic                    arst_n,
	input logic                    out_valid,
	input logic                    out_ready,
	input logic                    accepted,
	input logic [COUNT_BITS-1:0]   entry_count,
	input logic [POINT_BITS-1:0]   top_points,
	input logic                    read_valid,
	input logic [POINT_BITS-1:0]   read_points,
	input logic [PAYLOAD_BITS-1:0] read_payload
);

	localparam int unsigned WORD_W = 2 + COUNT_BITS + 2 * POINT_BITS + PAYLOAD_BITS;

	logic              count_ok;
	logic              flags_ok;
	logic              stored_ok;
	logic              read_zero_ok;
	logic              stalled;
	logic [WORD_W-1:0] res_word;

	assign count_ok     = entry_count <= COUNT_BITS'(TABLE_DEPTH);
	assign flags_ok     = !(accepted && read_valid);
	assign stored_ok    = !(accepted || read_valid) ||
		((entry_count != '0) && (top_points != '0) && (read_points <= top_points));
	assign read_zero_ok = read_valid || ((read_points == '0) && (read_payload == '0));
	assign stalled      = out_valid && !out_ready;
	assign res_word     = {accepted, entry_count, top_points, read_valid, read_points,
		read_payload};

	`ASSERT_ALWAYS(a_count_range, !out_valid || count_ok, "entry count beyond depth")

	`ASSERT_ALWAYS(a_acc_xor_read, !out_valid || flags_ok, "insert and read flags both set")

	`ASSERT_ALWAYS(a_nonempty, !out_valid || stored_ok, "stored entry inconsistent with count")

	`ASSERT_ALWAYS(a_read_zero, !out_valid || read_zero_ok, "read fields not zero")

	`ASSERT_NEXT(a_hold, stalled, out_valid && $stable(res_word), "result word changed")

endmodule

bind top_k_score_table tkst_checker #(
	.TABLE_DEPTH  (TABLE_DEPTH),
	.POINT_BITS   (POINT_BITS),
	.PAYLOAD_BITS (PAYLOAD_BITS)
) u_tkst_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.out_valid    (res.valid),
	.out_ready    (res.ready),
	.accepted     (res.accepted),
	.entry_count  (res.entry_count),
	.top_points   (res.top_points),
	.read_valid   (res.read_valid),
	.read_points  (res.read_points),
	.read_payload (res.read_payload)
);

/* verif/score_table_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// score_table_checker
// Watches both channels of the top-k score table and checks every result word.
// ----------------------------------------------------------------------------
// Keeps its own ranked copy of the table. Each command word taken by the block
// is applied to that copy, and the expected result is queued. Each result word
// handed over is compared field by field with the oldest queued result.
module score_table_checker import tkst_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	tkst_in_if   cmd,
	tkst_out_if  rsp,
	output int   fail_count,
	output int   pending,
	output int   inserts_placed,
	output int   reads_hit
);

	typedef struct packed {
		logic                        accepted;
		logic [COUNT_BITS-1:0]       entry_count;
		logic [DEF_POINT_BITS-1:0]   top_points;
		logic                        read_valid;
		logic [DEF_POINT_BITS-1:0]   read_points;
		logic [DEF_PAYLOAD_BITS-1:0] read_payload;
	} score_result_t;

	logic [DEF_POINT_BITS-1:0]   rank_pts [DEF_TABLE_DEPTH];
	logic [DEF_PAYLOAD_BITS-1:0] rank_pay [DEF_TABLE_DEPTH];
	int unsigned                 held;
	score_result_t               expected_q [$];

	// ties go after the entries already stored; a full table drops its last
	function automatic logic place_entry(logic [DEF_POINT_BITS-1:0] pts,
		logic [DEF_PAYLOAD_BITS-1:0] pay);
		int unsigned pos;
		int unsigned last;
		if (pts == '0)
			return 1'b0;
		if (held >= DEF_TABLE_DEPTH) begin
			if (pts <= rank_pts[DEF_TABLE_DEPTH-1])
				return 1'b0;
			last = DEF_TABLE_DEPTH - 1;
		end else begin
			last = held;
			held++;
		end
		pos = 0;
		while (pos < last && rank_pts[pos] >= pts)
			pos++;
		for (int unsigned i = last; i > pos; i--) begin
			rank_pts[i] = rank_pts[i-1];
			rank_pay[i] = rank_pay[i-1];
		end
		rank_pts[pos] = pts;
		rank_pay[pos] = pay;
		return 1'b1;
	endfunction

	function automatic score_result_t rank_word(action_t act,
		logic [DEF_POINT_BITS-1:0] pts, logic [DEF_PAYLOAD_BITS-1:0] pay,
		logic [READ_IDX_BITS-1:0] idx);
		score_result_t r;
		r = '0;
		if (act == ACT_INSERT) begin
			r.accepted = place_entry(pts, pay);
			if (r.accepted)
				inserts_placed++;
		end else if (idx < held) begin
			r.read_valid   = 1'b1;
			r.read_points  = rank_pts[idx];
			r.read_payload = rank_pay[idx];
			reads_hit++;
		end
		r.entry_count = COUNT_BITS'(held);
		r.top_points  = (held > 0) ? rank_pts[0] : '0;
		return r;
	endfunction

	function automatic void compare_field(string name, logic [31:0] want,
		logic [31:0] got);
		if (got !== want) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
			fail_count++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		score_result_t want;
		if (!arst_n) begin
			expected_q.delete();
			held           = 0;
			fail_count     = 0;
			pending        = 0;
			inserts_placed = 0;
			reads_hit      = 0;
		end else begin
			if (cmd.valid && cmd.ready)
				expected_q.push_back(rank_word(action_t'(cmd.action), cmd.new_points,
					cmd.new_payload, cmd.read_index));
			if (rsp.valid && rsp.ready) begin
				if (expected_q.size() == 0) begin
					$error("result word with no command word outstanding");
					fail_count++;
				end else begin
					want = expected_q.pop_front();
					compare_field("accepted", 32'(want.accepted), 32'(rsp.accepted));
					compare_field("entry_count", 32'(want.entry_count),
						32'(rsp.entry_count));
					compare_field("top_points", 32'(want.top_points), 32'(rsp.top_points));
					compare_field("read_valid", 32'(want.read_valid), 32'(rsp.read_valid));
					compare_field("read_points", 32'(want.read_points),
						32'(rsp.read_points));
					compare_field("read_payload", want.read_payload, rsp.read_payload);
				end
			end
			pending = expected_q.size();
		end
	end

endmodule

/* verif/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Stimulus and verdict for the top-k score table.
// ----------------------------------------------------------------------------
// A directed run covers the empty and full table, zero points, ties, drops
// off the end and reads inside and beyond the count. Random words then follow
// with rising point levels so the table keeps changing, across phases of
// sender gaps and receiver stalls. Checking is done by score_table_checker.
module testbench;
	import tkst_pkg::*;

	logic clk;
	logic arst_n;
	int   send_idle_pct;
	int   recv_stall_pct;
	int   words_sent;
	int   inserts_sent;
	int   reads_sent;
	int   fail_count;
	int   pending;
	int   inserts_placed;
	int   reads_hit;

	tkst_in_if  cmd_if ();
	tkst_out_if rsp_if ();

	top_k_score_table dut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (cmd_if),
		.res    (rsp_if)
	);

	score_table_checker checker_i (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd_if),
		.rsp            (rsp_if),
		.fail_count     (fail_count),
		.pending        (pending),
		.inserts_placed (inserts_placed),
		.reads_hit      (reads_hit)
	);

	initial clk = 1'b0;
	always #2 clk = ~clk;

	initial begin
		#2_000_000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin
		rsp_if.ready = 1'b0;
		forever begin
			@(negedge clk);
			rsp_if.ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	task automatic send_word(action_t act, logic [DEF_POINT_BITS-1:0] pts,
		logic [DEF_PAYLOAD_BITS-1:0] pay, logic [READ_IDX_BITS-1:0] idx);
		int gap;
		gap = 0;
		while (gap < 40 && $urandom_range(99) < send_idle_pct)
			gap++;
		@(negedge clk);
		if (gap > 0) begin
			cmd_if.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		cmd_if.valid       <= 1'b1;
		cmd_if.action      <= act;
		cmd_if.new_points  <= pts;
		cmd_if.new_payload <= pay;
		cmd_if.read_index  <= idx;
		do @(posedge clk); while (!cmd_if.ready);
		words_sent++;
		if (act == ACT_INSERT)
			inserts_sent++;
		else
			reads_sent++;
	endtask

	task automatic insert_word(logic [DEF_POINT_BITS-1:0] pts,
		logic [DEF_PAYLOAD_BITS-1:0] pay);
		send_word(ACT_INSERT, pts, pay, READ_IDX_BITS'($urandom));
	endtask

	task automatic read_word(logic [READ_IDX_BITS-1:0] idx);
		send_word(ACT_READ, DEF_POINT_BITS'($urandom), $urandom, idx);
	endtask

	task automatic random_word(int unsigned level);
		int unsigned roll;
		logic [DEF_POINT_BITS-1:0] pts;
		if ($urandom_range(99) < 40) begin
			read_word(READ_IDX_BITS'($urandom));
		end else begin
			roll = $urandom_range(99);
			if (roll < 60)
				pts = DEF_POINT_BITS'(level + $urandom_range(40));
			else if (roll < 75)
				pts = DEF_POINT_BITS'($urandom);
			else if (roll < 85)
				pts = '0;
			else if (roll < 99)
				pts = DEF_POINT_BITS'($urandom_range(1, 300));
			else
				pts = '1;
			insert_word(pts, $urandom);
		end
	endtask

	initial begin
		cmd_if.valid       = 1'b0;
		cmd_if.action      = ACT_INSERT;
		cmd_if.new_points  = '0;
		cmd_if.new_payload = '0;
		cmd_if.read_index  = '0;
		send_idle_pct      = 0;
		recv_stall_pct     = 0;
		words_sent         = 0;
		inserts_sent       = 0;
		reads_sent         = 0;
		arst_n             = 1'b0;
		repeat (4) @(negedge clk);
		arst_n = 1'b1;

		// empty table, zero points, extremes
		read_word(4'd0);
		read_word(4'd15);
		insert_word(16'd0, 32'hFFFF_FFFF);
		insert_word(16'hFFFF, 32'hFFFF_FFFF);
		insert_word(16'd1, 32'h0);
		// ties keep arrival order
		insert_word(16'd500, 32'hA);
		insert_word(16'd500, 32'hB);
		insert_word(16'd500, 32'hC);
		insert_word(16'hFFFF, 32'hD);
		insert_word(16'd300, 32'h1111_0000);
		insert_word(16'd700, 32'h2222_0000);
		insert_word(16'd2, 32'h3333_0000);
		insert_word(16'd900, 32'h4444_0000);
		// full: equal to last, zero, above last with a tie
		insert_word(16'd1, 32'h5555_5555);
		insert_word(16'd0, 32'h6666_6666);
		insert_word(16'd500, 32'hE);
		read_word(4'd0);
		read_word(4'd9);
		read_word(4'd10);
		read_word(4'd15);
		read_word(4'd3);
		insert_word(16'hFFFF, 32'hF);
		read_word(4'd1);
		insert_word(16'd2, 32'h7777_7777);
		read_word(4'd7);

		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 74; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 74; end
				default: begin send_idle_pct = 33; recv_stall_pct = 33; end
			endcase
			for (int n = 0; n < 275; n++)
				random_word(100 + (ph * 275 + n) * 55);
		end

		@(negedge clk);
		cmd_if.valid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (8) @(negedge clk);

		$display("Run covered %0d words: %0d inserts, %0d placed in the table;",
			words_sent, inserts_sent, inserts_placed);
		$display("%0d reads, %0d of them inside the count, over four pacing phases.",
			reads_sent, reads_hit);
		if (fail_count == 0 && pending == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
